[hw/rtl/sbr256_pkg.sv]
// ----------------------------------------------------------------------------
// sbr256_pkg
// Shared constants and the tempering function for the bounded random source.
// ----------------------------------------------------------------------------
package sbr256_pkg;

  localparam int unsigned MT_N = 312;
  localparam int unsigned MT_M = 156;

  localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;
  localparam logic [63:0] WORKER_K  = 64'hD1B54A32D192ED03;
  localparam logic [63:0] SEED_MUL  = 64'd6364136223846793005;
  localparam logic [63:0] TWIST_A   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UPPER_MSK = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LOWER_MSK = 64'h000000007FFFFFFF;

  function automatic logic [63:0] mt_temper(input logic [63:0] x);
    logic [63:0] y;
    y = x;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

[hw/rtl/sbr256_mul64.sv]
// ----------------------------------------------------------------------------
// sbr256_mul64
// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products. Operands, partial products and sum are registered in turn.
// ----------------------------------------------------------------------------
module sbr256_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [63:0] a_r, b_r;
  logic [1:0]  v_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], go};
    end
    a_r  <= a;
    b_r  <= b;
    ll_r <= {32'd0, a_r[31:0]} * {32'd0, b_r[31:0]};
    lh_r <= a_r[31:0] * b_r[63:32];
    hl_r <= a_r[63:32] * b_r[31:0];
    p_r  <= ll_r + {lh_r + hl_r, 32'd0};
  end

  logic d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= 1'b0;
    end else begin
      d_r <= v_r[1];
    end
  end

  assign done = d_r;
  assign p    = p_r;
endmodule

[hw/rtl/seeded_bounded_random_256_core.sv]
// ----------------------------------------------------------------------------
// seeded_bounded_random_256_core
// Per-worker MT19937-64 streams drawing values below a 256-bit bound.
// ----------------------------------------------------------------------------
// Usage: raise start with in_worker and in_bound_word0..3 while busy is low;
// that beat is taken. Busy stays high until the result beat, which shows on
// out_rand_word0..3 for one cycle with out_valid high. The receiver cannot
// stall, so the result is simply presented once.
// cfg_valid/cfg_ready write base_seed; cfg_ready is high while busy is low.
// Each drawn word passes S_DRAW, S_RDW and S_USE (read, wait, temper and
// store), and each attempt adds the compare in S_CHK; about two attempts
// are typical. After the last compare the result passes S_OUT and then the
// registered out_valid. The first use of a worker seeds its stream: S_MIX
// mixes the seed, then 311 words go through the shared 64-bit multiplier.
// A twist of a stream runs every 312 words, three memory reads and one write
// a word through S_TW0 to S_TW3 and S_TWW. All work serializes on the one
// memory and its single read port. Reset clears the started flags and
// base_seed; the memory is not cleared, since a stream is always seeded
// before it is read. A zero bound or worker outside WORKERS answers zero
// through S_OUT.
// ----------------------------------------------------------------------------
module seeded_bounded_random_256_core #(
  parameter int unsigned WORKERS    = 32,
  parameter int unsigned VALUE_BITS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_worker,
  input  logic [63:0] in_bound_word0,
  input  logic [63:0] in_bound_word1,
  input  logic [63:0] in_bound_word2,
  input  logic [63:0] in_bound_word3,
  output logic        out_valid,
  output logic [63:0] out_rand_word0,
  output logic [63:0] out_rand_word1,
  output logic [63:0] out_rand_word2,
  output logic [63:0] out_rand_word3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_base_seed
);
  import sbr256_pkg::*;

  localparam int unsigned WB    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned DEPTH = WORKERS * MT_N;
  localparam int unsigned AB    = $clog2(DEPTH);
  localparam int unsigned VW    = (VALUE_BITS + 63) / 64;
  localparam int unsigned TOPR  = VALUE_BITS % 64;
  localparam logic [63:0] TOPM  = (TOPR != 0) ? ((64'd1 << TOPR) - 64'd1) : '1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_MIX   = 14'b00000000000010,
    S_SEED  = 14'b00000000000100,
    S_SEEDW = 14'b00000000001000,
    S_DRAW  = 14'b00000000010000,
    S_RDW   = 14'b00000000100000,
    S_USE   = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_TW0   = 14'b00000100000000,
    S_TW1   = 14'b00001000000000,
    S_TW2   = 14'b00010000000000,
    S_TW3   = 14'b00100000000000,
    S_OUT   = 14'b01000000000000,
    S_TWW   = 14'b10000000000000
  } state_t;

  state_t state_r;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;
  logic [AB-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  logic [WORKERS-1:0] started_r;
  logic [8:0]         pos_r [WORKERS];
  logic [63:0]        seed_r;
  logic [WB-1:0]      w_r;
  logic [63:0]        bnd_r [4];
  logic [63:0]        val_r [4];
  logic [8:0]         bits_r;
  logic [2:0]         limbs_r;
  logic [1:0]         li_r;
  logic [8:0]         idx_r;
  logic [2:0]         step_r;
  logic [63:0]        prev_r, x_r;
  logic [AB-1:0]      base_r;

  logic        mgo, mdone;
  logic [63:0] ma, mb, mp;
  sbr256_mul64 u_mul (
    .clk(clk), .rst_n(rst_n), .go(mgo), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  // Bit length of the masked bound.
  logic [63:0] bm [4];
  logic [8:0]  blen;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bm[i] = (i < VW) ? ((i == VW - 1) ? (in_bound_word0 & '0) : 64'd0) : 64'd0;
    end
    bm[0] = (VW > 0) ? in_bound_word0 : 64'd0;
    bm[1] = (VW > 1) ? in_bound_word1 : 64'd0;
    bm[2] = (VW > 2) ? in_bound_word2 : 64'd0;
    bm[3] = (VW > 3) ? in_bound_word3 : 64'd0;
    bm[VW-1] = bm[VW-1] & TOPM;
    blen = '0;
    for (int i = 0; i < 256; i++) begin
      if (bm[i/64][i%64]) begin
        blen = 9'(i + 1);
      end
    end
  end

  logic in_range;
  assign in_range = ({27'd0, in_worker} < 32'(WORKERS));
  logic [WB-1:0] in_w;
  assign in_w = WB'(in_worker);

  logic [AB-1:0] wbase;
  assign wbase = AB'(32'(w_r) * MT_N);

  logic [8:0] pos_cur;
  assign pos_cur = pos_r[w_r];

  logic [8:0] idx1, idxm;
  assign idx1 = (idx_r == 9'(MT_N - 1)) ? 9'd0 : idx_r + 9'd1;
  assign idxm = (idx_r >= 9'(MT_N - MT_M)) ? idx_r - 9'(MT_N - MT_M) : idx_r + 9'(MT_M);

  logic [63:0] tw_x;
  assign tw_x = (x_r & UPPER_MSK) | (rdata_r & LOWER_MSK);

  logic [63:0] drawn, drawm;
  logic [5:0]  rem;
  assign drawn = mt_temper(rdata_r);
  assign rem   = bits_r[5:0];
  assign drawm = ({1'b0, li_r} == limbs_r - 3'd1 && rem != 6'd0)
               ? (drawn & ((64'd1 << rem) - 64'd1)) : drawn;

  logic lt;
  always_comb begin
    lt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (val_r[i] != bnd_r[i]) begin
        lt = (val_r[i] < bnd_r[i]);
      end
    end
  end

  always_comb begin
    mgo = 1'b0; ma = '0; mb = '0;
    raddr = base_r + AB'(idx_r);
    we = 1'b0; waddr = base_r + AB'(idx_r); wdata = prev_r;
    unique case (state_r)
      S_MIX: begin
        mgo = (step_r == 3'd1 || step_r == 3'd4);
        ma = x_r;
        mb = (step_r < 3'd4) ? MIX_MUL1 : MIX_MUL2;
      end
      S_SEED: begin
        mgo = 1'b1;
        ma  = prev_r ^ (prev_r >> 62);
        mb  = SEED_MUL;
      end
      S_SEEDW: begin
        we = mdone;
        wdata = mp + 64'(idx_r);
      end
      S_DRAW: begin
        raddr = wbase + AB'(pos_cur);
      end
      S_RDW: begin
        raddr = wbase + AB'(pos_cur - 9'd1);
      end
      S_TW0: begin
        raddr = base_r + AB'(idx_r);
      end
      S_TW1: begin
        raddr = base_r + AB'(idx1);
      end
      S_TW2: begin
        raddr = base_r + AB'(idxm);
      end
      S_TW3: begin
        raddr = base_r + AB'(idxm);
      end
      S_TWW: begin
        we = 1'b1;
        wdata = (step_r == 3'd6) ? prev_r
              : (rdata_r ^ ((prev_r >> 1) ^ (prev_r[0] ? TWIST_A : 64'd0)));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= '0;
      seed_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_OUT);
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_base_seed;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            w_r    <= in_w;
            bits_r <= blen;
            limbs_r <= 3'((blen + 9'd63) >> 6);
            for (int i = 0; i < 4; i++) begin
              bnd_r[i] <= bm[i];
              val_r[i] <= '0;
            end
            li_r <= '0;
            base_r <= AB'(32'(in_w) * MT_N);
            if (!in_range || blen == 9'd0) begin
              state_r <= S_OUT;
            end else if (!started_r[in_w]) begin
              x_r <= (seed_r ^ (WORKER_K * 64'({27'd0, in_worker} + 32'd1))) + GOLDEN;
              step_r <= '0;
              state_r <= S_MIX;
            end else begin
              state_r <= S_DRAW;
            end
          end
        end
        S_MIX: begin
          if (step_r == 3'd0) begin
            x_r <= x_r ^ (x_r >> 30);
            step_r <= 3'd1;
          end else if (step_r == 3'd1) begin
            step_r <= 3'd2;
          end else if (step_r == 3'd2 || step_r == 3'd3) begin
            if (mdone) begin
              x_r <= mp ^ (mp >> 27);
              step_r <= 3'd4;
            end else begin
              step_r <= 3'd3;
            end
          end else begin
            if (mdone) begin
              prev_r <= mp ^ (mp >> 31);
              idx_r <= '0;
              state_r <= S_TWW;
              step_r <= 3'd6;
            end else begin
              step_r <= 3'd5;
            end
          end
        end
        S_SEED: begin
          idx_r <= idx_r + 9'd1;
          state_r <= S_SEEDW;
        end
        S_SEEDW: begin
          if (mdone) begin
            prev_r <= mp + 64'(idx_r);
            if (idx_r == 9'(MT_N - 1)) begin
              started_r[w_r] <= 1'b1;
              pos_r[w_r] <= 9'(MT_N);
              state_r <= S_DRAW;
            end else begin
              state_r <= S_SEED;
            end
          end
        end
        S_DRAW: begin
          if (pos_cur >= 9'(MT_N)) begin
            idx_r <= '0;
            state_r <= S_TW0;
          end else begin
            pos_r[w_r] <= pos_cur + 9'd1;
            state_r <= S_RDW;
          end
        end
        S_RDW: state_r <= S_USE;
        S_USE: begin
          val_r[li_r] <= drawm;
          if ({1'b0, li_r} == limbs_r - 3'd1) begin
            state_r <= S_CHK;
          end else begin
            li_r <= li_r + 2'd1;
            state_r <= S_DRAW;
          end
        end
        S_CHK: begin
          li_r <= '0;
          if (lt) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_DRAW;
          end
        end
        S_TW0: state_r <= S_TW1;
        S_TW1: begin
          x_r <= rdata_r;
          state_r <= S_TW2;
        end
        S_TW2: begin
          prev_r <= tw_x;
          state_r <= S_TW3;
        end
        S_TW3: state_r <= S_TWW;
        S_TWW: begin
          if (step_r == 3'd6) begin
            step_r <= '0;
            state_r <= S_SEED;
          end else if (idx_r == 9'(MT_N - 1)) begin
            pos_r[w_r] <= '0;
            state_r <= S_DRAW;
          end else begin
            idx_r <= idx_r + 9'd1;
            state_r <= S_TW0;
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_rand_word0 = val_r[0];
  assign out_rand_word1 = val_r[1];
  assign out_rand_word2 = val_r[2];
  assign out_rand_word3 = val_r[3];

`ifndef NO_ASSERTIONS
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_out_lt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && lt) |=> state_r == S_OUT) else $error("accepted value lost");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("beat not taken");
`endif
endmodule

[tb/seeded_bounded_random_256_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seeded_bounded_random_256_core_test
// Drives worker/bound beats into the core, with random sender gaps in some
// phases, and rewrites base_seed between phases. Every result beat is
// compared word by word with a local MT19937-64 rejection-sampling predictor.
// ----------------------------------------------------------------------------
module seeded_bounded_random_256_core_test;
  import sbr256_pkg::*;

  localparam int NWORKERS = 32;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [4:0]  in_worker;
  logic [63:0] in_bound_word0, in_bound_word1, in_bound_word2, in_bound_word3;
  logic        out_valid;
  logic [63:0] out_rand_word0, out_rand_word1, out_rand_word2, out_rand_word3;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_base_seed;

  seeded_bounded_random_256_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_worker(in_worker),
    .in_bound_word0(in_bound_word0), .in_bound_word1(in_bound_word1),
    .in_bound_word2(in_bound_word2), .in_bound_word3(in_bound_word3),
    .out_valid(out_valid),
    .out_rand_word0(out_rand_word0), .out_rand_word1(out_rand_word1),
    .out_rand_word2(out_rand_word2), .out_rand_word3(out_rand_word3),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_base_seed(cfg_base_seed)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [63:0]  seed_model;
  logic [63:0]  stream_words [NWORKERS][MT_N];
  int           stream_pos [NWORKERS];
  bit           stream_live [NWORKERS];
  logic [255:0] pending_values [$];
  int           error_count;
  int           burst_left;
  bit           gaps_on;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] splitmix_final(input logic [63:0] s);
    logic [63:0] x;
    x = s + GOLDEN;
    x = (x ^ (x >> 30)) * MIX_MUL1;
    x = (x ^ (x >> 27)) * MIX_MUL2;
    return x ^ (x >> 31);
  endfunction

  function automatic void seed_stream(input int w, input logic [63:0] s);
    stream_words[w][0] = s;
    for (int i = 1; i < MT_N; i++) begin
      stream_words[w][i] = SEED_MUL * (stream_words[w][i-1] ^ (stream_words[w][i-1] >> 62))
                           + 64'(i);
    end
    stream_pos[w] = MT_N;
  endfunction

  function automatic void twist_stream(input int w);
    logic [63:0] x;
    logic [63:0] xa;
    for (int i = 0; i < MT_N; i++) begin
      x = (stream_words[w][i] & UPPER_MSK) | (stream_words[w][(i + 1) % MT_N] & LOWER_MSK);
      xa = x >> 1;
      if (x[0]) begin
        xa = xa ^ TWIST_A;
      end
      stream_words[w][i] = stream_words[w][(i + MT_M) % MT_N] ^ xa;
    end
    stream_pos[w] = 0;
  endfunction

  function automatic logic [63:0] next_stream_word(input int w);
    logic [63:0] y;
    if (stream_pos[w] >= MT_N) begin
      twist_stream(w);
    end
    y = stream_words[w][stream_pos[w]];
    stream_pos[w]++;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    return y ^ (y >> 43);
  endfunction

  function automatic logic [255:0] draw_below(input int w, input logic [255:0] bound);
    int nbits;
    int nwords;
    logic [255:0] v;
    nbits = 0;
    if (bound == '0) begin
      return '0;
    end
    for (int i = 255; i >= 0; i--) begin
      if (bound[i] && nbits == 0) begin
        nbits = i + 1;
      end
    end
    if (!stream_live[w]) begin
      seed_stream(w, splitmix_final(seed_model ^ (WORKER_K * (64'(w) + 64'd1))));
      stream_live[w] = 1'b1;
    end
    nwords = (nbits + 63) / 64;
    do begin
      v = '0;
      for (int i = 0; i < nwords; i++) begin
        v[i*64 +: 64] = next_stream_word(w);
      end
      if (nbits % 64 != 0) begin
        v[(nwords-1)*64 +: 64] = v[(nwords-1)*64 +: 64] & ((64'd1 << (nbits % 64)) - 64'd1);
      end
    end while (!(v < bound));
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    logic [255:0] want;
    logic [255:0] got;
    if (rst_n && out_valid) begin
      got = {out_rand_word3, out_rand_word2, out_rand_word1, out_rand_word0};
      if (pending_values.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_values.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (want[i*64 +: 64] !== got[i*64 +: 64]) begin
            report_mismatch($sformatf("out_rand_word%0d expected %h got %h",
                                      i, want[i*64 +: 64], got[i*64 +: 64]));
          end
        end
      end
    end
  end

  task automatic send_item(input logic [4:0] w, input logic [255:0] bound);
    @(negedge clk);
    start <= 1'b1;
    in_worker <= w;
    {in_bound_word3, in_bound_word2, in_bound_word1, in_bound_word0} <= bound;
    do @(posedge clk); while (busy);
    pending_values.push_back(draw_below(w, bound));
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_paced(input logic [4:0] w, input logic [255:0] bound);
    if (gaps_on && burst_left == 0) begin
      pause_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    send_item(w, bound);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (pending_values.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_base_seed(input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_base_seed <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [255:0] random_bound();
    logic [255:0] b;
    int t;
    int sel;
    b = {rand64(), rand64(), rand64(), rand64()};
    t = $urandom_range(0, 3);
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      return '0;
    end
    if (sel == 1) begin
      return 256'd1 << $urandom_range(0, 255);
    end
    b = b >> ((3 - t) * 64);
    b = b >> $urandom_range(0, 63);
    return b;
  endfunction

  task automatic test_extremes();
    write_base_seed(64'd0);
    send_item(5'd0, '0);
    send_item(5'd0, 256'd1);
    send_item(5'd0, 256'd2);
    send_item(5'd1, '1);
    send_item(5'd1, 256'd1 << 63);
    send_item(5'd2, 256'd1 << 64);
    send_item(5'd2, 256'd1 << 255);
    send_item(5'd3, {64'h8000000000000001, 192'd0});
    send_item(5'd3, {128'd0, 64'hFFFFFFFFFFFFFFFF, 64'd0});
    send_item(5'd31, {64'd0, 64'h1, 128'd0});
    send_item(5'd31, {192'd0, 64'hFFFFFFFFFFFFFFFF});
    send_item(5'd0, 256'd3);
    send_item(5'd1, '0);
    send_item(5'd30, 256'd12345);
    wait_idle();
  endtask

  task automatic test_reseed_keeps_started();
    write_base_seed(64'hFFFFFFFFFFFFFFFF);
    for (int i = 0; i < 8; i++) begin
      send_item(5'(4 + i % 4), random_bound());
      send_item(5'(i % 4), random_bound());
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_base_seed(rand64());
      gaps_on = (phase != 2);
      burst_left = 0;
      for (int n = 0; n < 345; n++) begin
        send_paced(5'($urandom_range(0, NWORKERS - 1)), random_bound());
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_worker = '0;
    in_bound_word0 = '0;
    in_bound_word1 = '0;
    in_bound_word2 = '0;
    in_bound_word3 = '0;
    cfg_valid = 1'b0;
    cfg_base_seed = '0;
    seed_model = '0;
    error_count = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    for (int w = 0; w < NWORKERS; w++) begin
      stream_live[w] = 1'b0;
      stream_pos[w] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_reseed_keeps_started();
    test_random_traffic();
    if (error_count == 0 && pending_values.size() == 0) begin
      $display("seeded_bounded_random_256_core: match");
    end else begin
      $display("seeded_bounded_random_256_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("seeded_bounded_random_256_core: mismatch");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sbr256_pkg.sv
hw/rtl/sbr256_mul64.sv
hw/rtl/seeded_bounded_random_256_core.sv
tb/seeded_bounded_random_256_core_test.sv
